>>> src/framed_command_packet_parser_core_macros.svh
// Assertion macros for the command packet parser checker
`ifndef FRAMED_COMMAND_PACKET_PARSER_CORE_MACROS_SVH
`define FRAMED_COMMAND_PACKET_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define FCPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcpp check failed");

// next-cycle implication, sampled on clk, off during rst
`define FCPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcpp check failed");

`endif

>>> src/fcpp_pkg.sv
// Shared types and constants for the command packet parser
`default_nettype none

package fcpp_pkg;

  localparam int STORE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int MAXPL_W = 4;
  localparam int COUNT_W = 5;
  localparam int KIND_W = 2;
  localparam int WORD_W = 16;
  localparam int OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [BYTE_W-1:0] HDR_FIRST_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'h55;
  localparam logic [MAXPL_W-1:0] MAX_PAYLOAD_RST = 4'd10;

  localparam logic [BYTE_W-1:0] ID_BASE_CTRL = 8'h01;
  localparam logic [BYTE_W-1:0] ID_CTRL_REQ = 8'h0E;
  localparam logic [BYTE_W-1:0] ID_EXT_REQ = 8'h09;

  // frame offset of the first payload byte (two header bytes, one length byte)
  localparam int PAYLOAD_OFS = 3;

  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CTRL_REQ = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EXT_REQ = 2'd3;

  typedef struct packed {
    logic                     done;
    logic [KIND_W-1:0]        kind;
    logic [BYTE_W-1:0]        id;
    logic signed [WORD_W-1:0] speed;
    logic signed [WORD_W-1:0] radius;
    logic [BYTE_W-1:0]        flag;
  } result_t;

endpackage

`default_nettype wire

>>> src/fcpp_queue.sv
// Small result queue between the parser front and the output stage
`default_nettype none

module fcpp_queue #(
  parameter int DEPTH = fcpp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire fcpp_pkg::result_t wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output fcpp_pkg::result_t     rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  fcpp_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_FULL);
  assign empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/fcpp_front.sv
// Parser front: header hunt, length, payload capture and packet classification
`default_nettype none

module fcpp_front #(
  parameter int STORE_DEPTH = fcpp_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [fcpp_pkg::BYTE_W-1:0]        in_byte,
  input  wire logic                               cfg_we,
  input  wire logic [fcpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fcpp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               q_full,
  output logic                                    push,
  output fcpp_pkg::result_t                       rec
);

  typedef enum logic [1:0] {
    PH_CLEAR,
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  localparam int CW = fcpp_pkg::COUNT_W;
  localparam int BW = fcpp_pkg::BYTE_W;
  localparam int LW = BW + 1;

  // payload bytes kept only where they fall inside the store
  localparam bit OK0 = (fcpp_pkg::PAYLOAD_OFS + 0) < STORE_DEPTH;
  localparam bit OK2 = (fcpp_pkg::PAYLOAD_OFS + 2) < STORE_DEPTH;
  localparam bit OK3 = (fcpp_pkg::PAYLOAD_OFS + 3) < STORE_DEPTH;
  localparam bit OK4 = (fcpp_pkg::PAYLOAD_OFS + 4) < STORE_DEPTH;
  localparam bit OK5 = (fcpp_pkg::PAYLOAD_OFS + 5) < STORE_DEPTH;

  localparam logic [CW-1:0] OFS_B0 = CW'(fcpp_pkg::PAYLOAD_OFS + 0);
  localparam logic [CW-1:0] OFS_B2 = CW'(fcpp_pkg::PAYLOAD_OFS + 2);
  localparam logic [CW-1:0] OFS_B3 = CW'(fcpp_pkg::PAYLOAD_OFS + 3);
  localparam logic [CW-1:0] OFS_B4 = CW'(fcpp_pkg::PAYLOAD_OFS + 4);
  localparam logic [CW-1:0] OFS_B5 = CW'(fcpp_pkg::PAYLOAD_OFS + 5);

  logic [BW-1:0] hdr_first;
  logic [BW-1:0] hdr_second;
  logic [fcpp_pkg::MAXPL_W-1:0] max_payload;

  phase_t phase;
  phase_t phase_next;
  phase_t ph;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] cnt;
  logic [BW-1:0] plen;
  logic [BW-1:0] plen_next;
  logic [BW-1:0] want;
  logic done;

  logic [BW-1:0] pb0, pb2, pb3, pb4, pb5;
  logic [BW-1:0] v0, v2, v3, v4, v5;

  assign in_ready = !q_full;
  assign push = in_valid && in_ready;

  always_comb begin
    ph = phase;
    cnt = count;
    if (phase == PH_CLEAR) begin
      ph = PH_HEADER;
      cnt = '0;
    end
    phase_next = ph;
    count_next = cnt;
    plen_next = plen;
    done = 1'b0;
    want = (cnt == '0) ? hdr_first : hdr_second;
    case (ph)
      PH_HEADER: begin
        if (cnt > CW'(1) || in_byte != want) begin
          count_next = '0;
        end else begin
          count_next = cnt + CW'(1);
          if (cnt == CW'(1)) begin
            phase_next = PH_LENGTH;
          end
        end
      end
      PH_LENGTH: begin
        count_next = cnt + CW'(1);
        plen_next = in_byte;
        phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        count_next = cnt + CW'(1);
        if (plen > BW'(max_payload)) begin
          phase_next = PH_CLEAR;
        end else if (LW'(cnt) + LW'(1) >= LW'(plen) + LW'(4)) begin
          done = 1'b1;
          phase_next = PH_CLEAR;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_first <= fcpp_pkg::HDR_FIRST_RST;
      hdr_second <= fcpp_pkg::HDR_SECOND_RST;
      max_payload <= fcpp_pkg::MAX_PAYLOAD_RST;
      phase <= PH_CLEAR;
      count <= '0;
      plen <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fcpp_pkg::CFG_HDR_FIRST:   hdr_first <= cfg_data;
          fcpp_pkg::CFG_HDR_SECOND:  hdr_second <= cfg_data;
          fcpp_pkg::CFG_MAX_PAYLOAD: max_payload <= cfg_data[fcpp_pkg::MAXPL_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        phase <= phase_next;
        count <= count_next;
        plen <= plen_next;
      end
    end
  end

  // only the payload bytes that the decode reads are kept
  always_ff @(posedge clk) begin
    if (push && ph == PH_PAYLOAD) begin
      case (cnt)
        OFS_B0:  pb0 <= in_byte;
        OFS_B2:  pb2 <= in_byte;
        OFS_B3:  pb3 <= in_byte;
        OFS_B4:  pb4 <= in_byte;
        OFS_B5:  pb5 <= in_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    v0 = (OK0 && plen > BW'(0)) ? pb0 : '0;
    v2 = (OK2 && plen > BW'(2)) ? pb2 : '0;
    v3 = (OK3 && plen > BW'(3)) ? pb3 : '0;
    v4 = (OK4 && plen > BW'(4)) ? pb4 : '0;
    v5 = (OK5 && plen > BW'(5)) ? pb5 : '0;
    rec = '0;
    if (done) begin
      rec.done = 1'b1;
      rec.id = v0;
      if (v0 == fcpp_pkg::ID_BASE_CTRL) begin
        rec.kind = fcpp_pkg::KIND_BASE;
        rec.speed = {v3, v2};
        rec.radius = {v5, v4};
      end else if (v0 == fcpp_pkg::ID_CTRL_REQ) begin
        rec.kind = fcpp_pkg::KIND_CTRL_REQ;
      end else if (v0 == fcpp_pkg::ID_EXT_REQ) begin
        rec.kind = fcpp_pkg::KIND_EXT_REQ;
        rec.flag = v2;
      end else begin
        rec.kind = fcpp_pkg::KIND_OTHER;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/fcpp_back.sv
// Output stage: registers queued results onto the master stream
`default_nettype none

module fcpp_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_empty,
  input  wire fcpp_pkg::result_t                   q_data,
  output logic                                     pop,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [fcpp_pkg::OUT_DATA_W-1:0]          m_tdata,
  output logic                                     m_tlast,
  output logic [fcpp_pkg::KIND_W-1:0]              m_tuser
);

  fcpp_pkg::result_t hold;

  assign pop = !q_empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= q_data;
    end
  end

  assign m_tdata = {hold.flag, hold.radius, hold.speed, hold.id};
  assign m_tlast = hold.done;
  assign m_tuser = hold.kind;

endmodule

`default_nettype wire

>>> src/framed_command_packet_parser_core.sv
// Top level of the framed command packet parser
//
// Slave stream: one received serial byte per beat on s_tdata. Every byte
// gives exactly one result beat on the master stream, in order.
// Master stream: m_tlast is high on the beat of the byte that completed a
// packet (the checksum byte); m_tuser then holds the packet kind and
// m_tdata the id, speed, radius and extended flag. Other beats carry zeros.
// Config: cfg_we writes cfg_data to register cfg_index (0 first header
// byte, 1 second header byte, 2 payload limit); write only while idle.
// Path: a byte taken is written into the queue, then into the output
// register once the output is free. Throughput: one byte per cycle while
// s_tready is high; the parser state advances on every accepted byte.
// Reset: header bytes return to 0xAA/0x55, limit to 10, parser hunts for
// a new header, queue and output register are emptied.
// Stall: the two-entry queue and the output register hold up to three
// results; after that s_tready drops until the receiver takes a beat.
`default_nettype none

module framed_command_packet_parser_core #(
  parameter int STORE_DEPTH = fcpp_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [fcpp_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] rx_byte
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [7:0] payload_id, [23:8] drive_speed, [39:24] turn_radius, [47:40] ext_flag
  output logic [fcpp_pkg::OUT_DATA_W-1:0]         m_tdata,
  output logic                                    m_tlast,   // packet_done
  output logic [fcpp_pkg::KIND_W-1:0]             m_tuser,   // [1:0] packet_kind
  input  wire logic                               cfg_we,
  input  wire logic [fcpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fcpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  fcpp_pkg::result_t rec;
  fcpp_pkg::result_t q_data;

  fcpp_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .rec       (rec)
  );

  fcpp_queue #(
    .DEPTH(fcpp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (rec),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  fcpp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

>>> src/fcpp_checker.sv
// Port-level checks for the command packet parser, bound to the top level
`default_nettype none
`include "framed_command_packet_parser_core_macros.svh"

module fcpp_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic [fcpp_pkg::BYTE_W-1:0]        s_tdata,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [fcpp_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire logic                               m_tlast,
  input wire logic [fcpp_pkg::KIND_W-1:0]        m_tuser,
  input wire logic                               cfg_we,
  input wire logic [fcpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic [fcpp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic unused_ok;
  assign unused_ok = &{s_tvalid, s_tready, s_tdata, cfg_we, cfg_index, cfg_data};

  `FCPP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `FCPP_ASSERT_NOW(a_idle_zero, m_tvalid && !m_tlast, m_tuser == '0 && m_tdata == '0)
  `FCPP_ASSERT_NOW(a_drive_only_base, m_tvalid && m_tuser != fcpp_pkg::KIND_BASE, m_tdata[39:8] == '0)
  `FCPP_ASSERT_NOW(a_flag_only_ext, m_tvalid && m_tuser != fcpp_pkg::KIND_EXT_REQ, m_tdata[47:40] == '0)

endmodule

bind framed_command_packet_parser_core fcpp_checker u_fcpp_checker (.*);

`default_nettype wire
